[src/terminal_line_controller_core_defines.svh]
// Assertion macros for the terminal line controller.
// Used by terminal_line_controller_core; no other dependencies.
`ifndef TERMINAL_LINE_CONTROLLER_CORE_DEFINES_SVH
`define TERMINAL_LINE_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define TLC_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("tlc: assertion failed");
// Next-cycle implication
`define TLC_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("tlc: assertion failed");
`else
`define TLC_ASSERT_IMPL(name, clk_sig, rst_sig, ante, cons)
`define TLC_ASSERT_NEXT(name, clk_sig, rst_sig, ante, cons)
`endif

`endif

[src/tlc_pkg.sv]
// Shared constants, types and address helpers for the terminal line controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tlc_pkg;

  // Geometry
  localparam int LINE_COLS  = 80;
  localparam int TERMINALS  = 4;
  localparam int KEY_CAP    = LINE_COLS - 2;
  localparam int LINE_BYTES = LINE_COLS + 1;
  localparam int WRAP_LEN   = LINE_COLS - 1;
  localparam int LINE_DEPTH = TERMINALS * LINE_BYTES;
  localparam int KEY_DEPTH  = TERMINALS * KEY_CAP;

  // Widths
  localparam int TERM_W  = 2;
  localparam int LEN_W   = 7;
  localparam int LADDR_W = $clog2(LINE_DEPTH);
  localparam int KADDR_W = $clog2(KEY_DEPTH);
  localparam int KIDX_W  = $clog2(KEY_CAP);
  localparam int KCNT_W  = $clog2(KEY_CAP + 1);

  localparam logic [7:0] NEWLINE = 8'h0A;

  // Register offsets within a terminal's group
  localparam logic [1:0] SUB_KEY_DATA = 2'd0;
  localparam logic [1:0] SUB_KEY_STAT = 2'd1;
  localparam logic [1:0] SUB_SCR_DATA = 2'd2;
  localparam logic [1:0] SUB_SCR_STAT = 2'd3;

  typedef enum logic [2:0] {
    OP_BUS_RD  = 3'd0,
    OP_BUS_WR  = 3'd1,
    OP_TICK    = 3'd2,
    OP_PUSH    = 3'd3,
    OP_CLR_OUT = 3'd4,
    OP_PEEK    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_DEV = 2'd1,
    ST_BUSY    = 2'd2,
    ST_BAD_OP  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_SCROLL = 2'd1,
    MODE_CLEAR  = 2'd2
  } line_mode_t;

  // What a latched command needs doing
  typedef enum logic [2:0] {
    ACT_RESP,
    ACT_POP,
    ACT_PUSH,
    ACT_PUT,
    ACT_NEWLINE,
    ACT_CLR_OUT,
    ACT_PEEK,
    ACT_TICK
  } act_t;

  // Source of read_data in the result
  typedef enum logic [2:0] {
    RS_ZERO,
    RS_KEY,
    RS_KEY_FLAG,
    RS_NORMAL_FLAG,
    RS_LINE
  } rsel_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_SWEEP,
    CMD_LATCH,
    CMD_KEY_RD,
    CMD_KEY_POP,
    CMD_KEY_PUSH,
    CMD_NEWLINE,
    CMD_PUT_CH,
    CMD_PUT_TERM,
    CMD_ZERO_HEAD,
    CMD_CLR_OUT,
    CMD_PEEK_RD,
    CMD_TICK_INIT,
    CMD_TICK_NEXT,
    CMD_SCR_RD,
    CMD_SCR_WR,
    CMD_SCR_TERM,
    CMD_CLR_RD0,
    CMD_CLR_SHIFT,
    CMD_CLR_END
  } dp_op_t;

  typedef enum logic [3:0] {
    S_SWEEP,
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_RESP,
    S_PUT_TERM,
    S_PUT_HEAD,
    S_TICK_EVAL,
    S_SCR_WR,
    S_SCR_TERM,
    S_CLR_SHIFT,
    S_CLR_END,
    S_TICK_NEXT
  } tlc_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   resp;
  } dp_cmd_t;

  typedef struct packed {
    act_t       act;
    logic       put_wrap;
    logic       scr_more;
    logic       clr_last;
    logic       tick_last;
    line_mode_t tt_mode;
    logic       tt_empty;
    logic       sweep_done;
  } dp_stat_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] device_id;
    logic [7:0] data;
    logic [1:0] terminal;
    logic [6:0] column;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_data;
    logic [6:0] visible_length;
    logic [1:0] output_mode;
  } result_t;

  // Flat line memory address of a terminal's byte
  function automatic logic [LADDR_W-1:0] lb_addr(input logic [TERM_W-1:0] t,
                                                 input logic [LEN_W-1:0] c);
    return LADDR_W'(t) * LADDR_W'(LINE_BYTES) + LADDR_W'(c);
  endfunction

  // Flat key memory address of a terminal's FIFO slot
  function automatic logic [KADDR_W-1:0] kb_addr(input logic [TERM_W-1:0] t,
                                                 input logic [KIDX_W-1:0] i);
    return KADDR_W'(t) * KADDR_W'(KEY_CAP) + KADDR_W'(i);
  endfunction

endpackage

[src/tlc_datapath.sv]
// Datapath: command decode, per-terminal state, key FIFO and line memories, result register.
// Depends on tlc_pkg; driven by tlc_controller.
`timescale 1ns / 1ps

module tlc_datapath import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output result_t  result,
  output logic     done
);

  // Per-terminal state
  logic [LEN_W-1:0]  len   [TERMINALS];
  line_mode_t        mode  [TERMINALS];
  logic [KIDX_W-1:0] head  [TERMINALS];
  logic [KCNT_W-1:0] count [TERMINALS];

  // Latched command
  logic [TERM_W-1:0] term;
  logic              bad_term;
  logic [7:0]        data;
  logic [LEN_W-1:0]  col;
  act_t              act;
  status_t           rstat;
  rsel_t             rsel;

  // Sequencing counters
  logic [TERM_W-1:0]  tt;
  logic [LEN_W-1:0]   idx;
  logic [LADDR_W-1:0] sweep_ptr;

  // Memories
  logic [7:0] line_mem [LINE_DEPTH];
  logic [7:0] key_mem  [KEY_DEPTH];
  logic [7:0] line_rdata;
  logic [7:0] key_rdata;

  // Decode of the incoming command
  logic [2:0]        dec_t3;
  logic [TERM_W-1:0] dec_t;
  logic [1:0]        dec_sub;
  logic              dec_bad;
  act_t              dec_act;
  status_t           dec_st;
  rsel_t             dec_rs;

  always_comb begin
    dec_sub = request.device_id[1:0];
    if (request.opcode == OP_BUS_RD || request.opcode == OP_BUS_WR) begin
      dec_t3 = request.device_id[4:2];
    end else begin
      dec_t3 = {1'b0, request.terminal};
    end
    dec_t   = dec_t3[TERM_W-1:0];
    dec_bad = (int'(dec_t3) >= TERMINALS);
    dec_act = ACT_RESP;
    dec_st  = ST_OK;
    dec_rs  = RS_ZERO;
    if (dec_bad) begin
      dec_st = ST_BAD_DEV;
    end else begin
      case (opcode_t'(request.opcode))
        OP_BUS_RD: begin
          unique case (dec_sub)
            SUB_KEY_DATA: begin
              if (count[dec_t] == '0) begin
                dec_st = ST_BUSY;
              end else begin
                dec_act = ACT_POP;
                dec_rs  = RS_KEY;
              end
            end
            SUB_KEY_STAT: dec_rs = RS_KEY_FLAG;
            SUB_SCR_DATA: dec_st = ST_BAD_OP;
            SUB_SCR_STAT: dec_rs = RS_NORMAL_FLAG;
            default:      dec_st = ST_BAD_OP;
          endcase
        end
        OP_BUS_WR: begin
          priority if (dec_sub != SUB_SCR_DATA) begin
            dec_st = ST_BAD_OP;
          end else if (mode[dec_t] != MODE_NORMAL) begin
            dec_st = ST_BUSY;
          end else if (request.data == 8'd0) begin
            dec_act = ACT_RESP;
          end else if (request.data == NEWLINE) begin
            dec_act = ACT_NEWLINE;
          end else if (len[dec_t] < LEN_W'(LINE_COLS)) begin
            dec_act = ACT_PUT;
          end else begin
            dec_act = ACT_RESP;
          end
        end
        OP_TICK: dec_act = ACT_TICK;
        OP_PUSH: begin
          if (request.data != 8'd0 && count[dec_t] < KCNT_W'(KEY_CAP)) begin
            dec_act = ACT_PUSH;
          end
        end
        OP_CLR_OUT: dec_act = ACT_CLR_OUT;
        OP_PEEK: begin
          if (request.column < LEN_W'(LINE_BYTES)) begin
            dec_act = ACT_PEEK;
            dec_rs  = RS_LINE;
          end else begin
            dec_st = ST_BAD_OP;
          end
        end
        default: dec_st = ST_BAD_OP;
      endcase
    end
  end

  // Derived values
  logic [7:0]        scr_next;
  logic [KIDX_W:0]   tail_sum;
  logic [KIDX_W-1:0] tail;
  logic [LEN_W-1:0]  clr_rd_col;

  always_comb begin
    scr_next   = (len[tt] == LEN_W'(LINE_COLS)) ? 8'd0 : line_rdata;
    tail_sum   = {1'b0, head[term]} + (KIDX_W+1)'(count[term]);
    tail       = (tail_sum >= (KIDX_W+1)'(KEY_CAP)) ?
                 KIDX_W'(tail_sum - (KIDX_W+1)'(KEY_CAP)) : KIDX_W'(tail_sum);
    clr_rd_col = (idx >= LEN_W'(LINE_COLS - 2)) ? LEN_W'(LINE_COLS) : idx + LEN_W'(2);
  end

  // Status to the controller
  always_comb begin
    stat.act        = act;
    stat.put_wrap   = (len[term] >= LEN_W'(WRAP_LEN - 1));
    stat.scr_more   = (scr_next != 8'd0);
    stat.clr_last   = ((idx + LEN_W'(1)) == len[tt]);
    stat.tick_last  = (int'(tt) == TERMINALS - 1);
    stat.tt_mode    = mode[tt];
    stat.tt_empty   = (len[tt] == '0);
    stat.sweep_done = (sweep_ptr == LADDR_W'(LINE_DEPTH - 1));
  end

  // Line memory port selection
  logic [LADDR_W-1:0] lraddr;
  logic [LADDR_W-1:0] lwaddr;
  logic [7:0]         lwdata;
  logic               lwe;

  always_comb begin
    unique case (cmd.op)
      CMD_PEEK_RD:   lraddr = lb_addr(term, col);
      CMD_SCR_RD:    lraddr = lb_addr(tt, (len[tt] == LEN_W'(LINE_COLS)) ?
                                          len[tt] : len[tt] + LEN_W'(1));
      CMD_CLR_RD0:   lraddr = lb_addr(tt, LEN_W'(1));
      CMD_CLR_SHIFT: lraddr = lb_addr(tt, clr_rd_col);
      default:       lraddr = lb_addr(tt, '0);
    endcase
  end

  always_comb begin
    lwe    = 1'b0;
    lwaddr = lb_addr(term, '0);
    lwdata = 8'd0;
    unique case (cmd.op)
      CMD_SWEEP: begin
        lwe    = 1'b1;
        lwaddr = sweep_ptr;
      end
      CMD_PUT_CH: begin
        lwe    = 1'b1;
        lwaddr = lb_addr(term, len[term]);
        lwdata = data;
      end
      CMD_PUT_TERM: begin
        lwe    = 1'b1;
        lwaddr = lb_addr(term, len[term] + LEN_W'(1));
      end
      CMD_ZERO_HEAD, CMD_CLR_OUT: begin
        lwe    = 1'b1;
      end
      CMD_SCR_WR: begin
        lwe    = 1'b1;
        lwaddr = lb_addr(tt, len[tt]);
        lwdata = scr_next;
      end
      CMD_SCR_TERM: begin
        lwe    = 1'b1;
        lwaddr = lb_addr(tt, len[tt] + LEN_W'(1));
      end
      CMD_CLR_SHIFT: begin
        lwe    = 1'b1;
        lwaddr = lb_addr(tt, idx);
        lwdata = line_rdata;
      end
      default: lwe = 1'b0;
    endcase
  end

  // Line memory
  always_ff @(posedge clk) begin
    if (lwe) begin
      line_mem[lwaddr] <= lwdata;
    end
    line_rdata <= line_mem[lraddr];
  end

  // Key FIFO memory
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_KEY_PUSH) begin
      key_mem[kb_addr(term, tail)] <= data;
    end
    key_rdata <= key_mem[kb_addr(term, head[term])];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TERMINALS; i++) begin
        len[i]   <= '0;
        mode[i]  <= MODE_NORMAL;
        head[i]  <= '0;
        count[i] <= '0;
      end
      tt        <= '0;
      idx       <= '0;
      sweep_ptr <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.resp;
      unique case (cmd.op)
        CMD_SWEEP:     sweep_ptr <= sweep_ptr + LADDR_W'(1);
        CMD_KEY_POP: begin
          head[term]  <= (head[term] == KIDX_W'(KEY_CAP - 1)) ? '0 :
                         head[term] + KIDX_W'(1);
          count[term] <= count[term] - KCNT_W'(1);
        end
        CMD_KEY_PUSH:  count[term] <= count[term] + KCNT_W'(1);
        CMD_NEWLINE:   mode[term] <= MODE_CLEAR;
        CMD_PUT_TERM: begin
          if (stat.put_wrap) begin
            mode[term] <= MODE_SCROLL;
            len[term]  <= '0;
          end else begin
            len[term]  <= len[term] + LEN_W'(1);
          end
        end
        CMD_CLR_OUT: begin
          len[term]  <= '0;
          mode[term] <= MODE_NORMAL;
        end
        CMD_TICK_INIT: tt <= '0;
        CMD_TICK_NEXT: tt <= tt + TERM_W'(1);
        CMD_SCR_WR: begin
          if (scr_next == 8'd0) begin
            mode[tt] <= MODE_NORMAL;
          end
        end
        CMD_SCR_TERM:  len[tt] <= len[tt] + LEN_W'(1);
        CMD_CLR_RD0:   idx <= '0;
        CMD_CLR_SHIFT: idx <= idx + LEN_W'(1);
        CMD_CLR_END: begin
          if (len[tt] <= LEN_W'(1)) begin
            mode[tt] <= MODE_NORMAL;
          end
          if (len[tt] != '0) begin
            len[tt] <= len[tt] - LEN_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Latched command fields
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LATCH) begin
      term     <= dec_t;
      bad_term <= dec_bad;
      data     <= request.data;
      col      <= request.column;
      act      <= dec_act;
      rstat    <= dec_st;
      rsel     <= dec_rs;
    end
  end

  // Result register
  logic [7:0] rd_mux;

  always_comb begin
    unique case (rsel)
      RS_KEY:         rd_mux = key_rdata;
      RS_KEY_FLAG:    rd_mux = {7'd0, count[term] != '0};
      RS_NORMAL_FLAG: rd_mux = {7'd0, mode[term] == MODE_NORMAL};
      RS_LINE:        rd_mux = line_rdata;
      default:        rd_mux = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      result.status         <= rstat;
      result.read_data      <= rd_mux;
      result.visible_length <= bad_term ? '0 : len[term];
      result.output_mode    <= bad_term ? MODE_NORMAL : mode[term];
    end
  end

endmodule

[src/tlc_controller.sv]
// Controller state machine: sequences datapath operations for each command transfer.
// Depends on tlc_pkg; drives tlc_datapath.
`timescale 1ns / 1ps

module tlc_controller import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  tlc_state_t state;
  tlc_state_t state_next;

  // State register; reset begins the line memory sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP:    if (stat.sweep_done) state_next = S_IDLE;
      S_IDLE:     if (start) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (stat.act)
          ACT_POP:  state_next = S_POP;
          ACT_PUT:  state_next = S_PUT_TERM;
          ACT_TICK: state_next = S_TICK_EVAL;
          ACT_PUSH, ACT_NEWLINE, ACT_CLR_OUT, ACT_PEEK: state_next = S_RESP;
          default:  state_next = S_IDLE;
        endcase
      end
      S_POP:      state_next = S_IDLE;
      S_RESP:     state_next = S_IDLE;
      S_PUT_TERM: state_next = stat.put_wrap ? S_PUT_HEAD : S_RESP;
      S_PUT_HEAD: state_next = S_RESP;
      S_TICK_EVAL: begin
        unique case (stat.tt_mode)
          MODE_SCROLL: state_next = S_SCR_WR;
          MODE_CLEAR:  state_next = stat.tt_empty ? S_TICK_NEXT : S_CLR_SHIFT;
          default:     state_next = S_TICK_NEXT;
        endcase
      end
      S_SCR_WR:    state_next = stat.scr_more ? S_SCR_TERM : S_TICK_NEXT;
      S_SCR_TERM:  state_next = S_TICK_NEXT;
      S_CLR_SHIFT: if (stat.clr_last) state_next = S_CLR_END;
      S_CLR_END:   state_next = S_TICK_NEXT;
      S_TICK_NEXT: state_next = stat.tick_last ? S_RESP : S_TICK_EVAL;
      default:     state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy     = (state != S_IDLE);
    cmd.op   = CMD_NONE;
    cmd.resp = 1'b0;
    unique case (state)
      S_SWEEP:    cmd.op = CMD_SWEEP;
      S_IDLE:     if (start) cmd.op = CMD_LATCH;
      S_DISPATCH: begin
        unique case (stat.act)
          ACT_POP:     cmd.op = CMD_KEY_RD;
          ACT_PUSH:    cmd.op = CMD_KEY_PUSH;
          ACT_PUT:     cmd.op = CMD_PUT_CH;
          ACT_NEWLINE: cmd.op = CMD_NEWLINE;
          ACT_CLR_OUT: cmd.op = CMD_CLR_OUT;
          ACT_PEEK:    cmd.op = CMD_PEEK_RD;
          ACT_TICK:    cmd.op = CMD_TICK_INIT;
          default:     cmd.resp = 1'b1;
        endcase
      end
      S_POP: begin
        cmd.op   = CMD_KEY_POP;
        cmd.resp = 1'b1;
      end
      S_RESP:     cmd.resp = 1'b1;
      S_PUT_TERM: cmd.op = CMD_PUT_TERM;
      S_PUT_HEAD: cmd.op = CMD_ZERO_HEAD;
      S_TICK_EVAL: begin
        unique case (stat.tt_mode)
          MODE_SCROLL: cmd.op = CMD_SCR_RD;
          MODE_CLEAR:  cmd.op = stat.tt_empty ? CMD_CLR_END : CMD_CLR_RD0;
          default:     cmd.op = CMD_NONE;
        endcase
      end
      S_SCR_WR:    cmd.op = CMD_SCR_WR;
      S_SCR_TERM:  cmd.op = CMD_SCR_TERM;
      S_CLR_SHIFT: cmd.op = CMD_CLR_SHIFT;
      S_CLR_END:   cmd.op = CMD_CLR_END;
      S_TICK_NEXT: if (!stat.tick_last) cmd.op = CMD_TICK_NEXT;
      default:     cmd.op = CMD_NONE;
    endcase
  end

endmodule

[src/terminal_line_controller_core.sv]
// Terminal line controller: a command is taken when start is high and busy is low.
// Its single result appears on result for exactly one cycle with done high, and
// the receiver cannot stall it, so it must be captured in that cycle. Of bus reads,
// writes, key pushes, output clears and peeks, a screen write that starts scrolling
// takes the longest from transfer to result. A tick walks the terminals in turn:
// a normal one is only checked, a scrolling one writes its next byte, a clearing
// one shifts its line one byte a cycle through the line memory's single write
// port and then shortens it, and an empty line only ends the clear. After reset
// the line memory is zeroed one byte a cycle, so busy stays high until that sweep ends.
// Depends on tlc_pkg, tlc_controller, tlc_datapath and the defines header.
`timescale 1ns / 1ps
`include "terminal_line_controller_core_defines.svh"

module terminal_line_controller_core import tlc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tlc_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  tlc_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

  // Checks
  `TLC_ASSERT_NEXT(a_transfer_sets_busy, clk, rst, start && !busy, busy)
  `TLC_ASSERT_IMPL(a_done_follows_work, clk, rst, done, $past(busy))
  `TLC_ASSERT_IMPL(a_mode_legal, clk, rst, done, result.output_mode != 2'd3)
  `TLC_ASSERT_IMPL(a_len_bound, clk, rst, done, result.visible_length <= 7'd80)

endmodule
